// ----- sv/ahsd_pkg.sv -----
// Constants, register indexes and helper functions for the highpass, slew and arcsine decoder.
// Depends on nothing; imported by the top level.
`default_nettype none

package ahsd_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int FRAC       = SAMPLE_W - 4;
  localparam int TAP_DEPTH  = 9;
  localparam int ADDR_W     = 5;
  localparam int X28_SHIFT  = 28 - FRAC;
  localparam int Q30_SHIFT  = 30 - FRAC;
  localparam int DIV_TERMS  = 5;

  localparam logic [32:0] PIO2_Q30 = 33'd1686629713;
  localparam logic [32:0] TURN_K   = 33'd683565276;
  localparam logic [32:0] BEND_Q30 = 33'd463296189;
  localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
  localparam logic [32:0] LEAK_Q28 = 33'd2684;
  localparam logic [32:0] KB_CAP   = 33'h0_4000_0000;

  localparam int SOFT_TH  = (610445635 + (1 << (Q30_SHIFT - 1))) >> Q30_SHIFT;
  localparam int PIO2_LIM = (1686629713 + (1 << (Q30_SHIFT - 1))) >> Q30_SHIFT;
  localparam int UNIT_LIM = 1 << FRAC;

  localparam logic [2:0] REG_IIR_RATE   = 3'd0;
  localparam logic [2:0] REG_TAP_SPACE  = 3'd1;
  localparam logic [2:0] REG_ULTRA_EN   = 3'd2;
  localparam logic [2:0] REG_COEF_A0    = 3'd3;
  localparam logic [2:0] REG_COEF_B1    = 3'd4;
  localparam logic [2:0] REG_COEF_B2    = 3'd5;

  localparam logic [2:0] SPACE_NONE = 3'd0;
  localparam logic [2:0] SPACE_ONE  = 3'd1;
  localparam logic [2:0] SPACE_TWO  = 3'd2;

  localparam logic [31:0] RECIP_110 = 32'((64'd1 << 32) / 64'd110);
  localparam logic [31:0] RECIP_72  = 32'((64'd1 << 32) / 64'd72);
  localparam logic [31:0] RECIP_42  = 32'((64'd1 << 32) / 64'd42);
  localparam logic [31:0] RECIP_20  = 32'((64'd1 << 32) / 64'd20);
  localparam logic [31:0] RECIP_6   = 32'((64'd1 << 32) / 64'd6);

  // Horner divisors, innermost term first
  function automatic logic [6:0] div_const(input logic [2:0] k);
    case (k)
      3'd0:    div_const = 7'd110;
      3'd1:    div_const = 7'd72;
      3'd2:    div_const = 7'd42;
      3'd3:    div_const = 7'd20;
      default: div_const = 7'd6;
    endcase
  endfunction

  function automatic logic [31:0] div_recip(input logic [2:0] k);
    case (k)
      3'd0:    div_recip = RECIP_110;
      3'd1:    div_recip = RECIP_72;
      3'd2:    div_recip = RECIP_42;
      3'd3:    div_recip = RECIP_20;
      default: div_recip = RECIP_6;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < -40'sd2147483648) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_samp(input logic signed [39:0] v);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = (40'sd1 <<< (SAMPLE_W - 1)) - 40'sd1;
    lo = -hi - 40'sd1;
    if (v > hi) begin
      sat_samp = hi[SAMPLE_W-1:0];
    end else if (v < lo) begin
      sat_samp = lo[SAMPLE_W-1:0];
    end else begin
      sat_samp = v[SAMPLE_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- sv/audio_highpass_slew_asin_decode.sv -----
// Highpass, slew softener, optional biquad lowpass and arcsine decoder, one sample per request.
// The arcsine search is 30 steps, each step a full sine on the one shared 33x33 multiplier;
// it is skipped when the clipped value reaches plus or minus one.
// Throughput: one request at a time; the next is taken once the previous has left the sequencer.
// Reset (synchronous, active high) clears the filter state and the delay line and sets the registers to their defaults.
// Depends on ahsd_pkg.
`default_nettype none

module audio_highpass_slew_asin_decode
  import ahsd_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire logic signed [SAMPLE_W-1:0] sample_in,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic signed [SAMPLE_W-1:0] sample_out,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ADDR_W-1:0]          paddr,
  input  wire logic [31:0]                pwdata,
  output      logic [31:0]                prdata,
  output      logic                       pready
);

  // One-hot sequencer. The sine routine (S0..S8) is shared by the bend and the arcsine search.
  typedef enum logic [33:0] {
    ST_IDLE = 34'd1 << 0,
    ST_HA   = 34'd1 << 1,
    ST_HB   = 34'd1 << 2,
    ST_HC   = 34'd1 << 3,
    ST_HD   = 34'd1 << 4,
    ST_HE   = 34'd1 << 5,
    ST_HF   = 34'd1 << 6,
    ST_SL   = 34'd1 << 7,
    ST_BP   = 34'd1 << 8,
    ST_BPH  = 34'd1 << 9,
    ST_S0   = 34'd1 << 10,
    ST_S1   = 34'd1 << 11,
    ST_S2   = 34'd1 << 12,
    ST_S3   = 34'd1 << 13,
    ST_S4   = 34'd1 << 14,
    ST_S5   = 34'd1 << 15,
    ST_S6   = 34'd1 << 16,
    ST_S7   = 34'd1 << 17,
    ST_S8   = 34'd1 << 18,
    ST_BR0  = 34'd1 << 19,
    ST_BR1  = 34'd1 << 20,
    ST_BR2  = 34'd1 << 21,
    ST_CLIP = 34'd1 << 22,
    ST_BQ0  = 34'd1 << 23,
    ST_BQ1  = 34'd1 << 24,
    ST_BQ2  = 34'd1 << 25,
    ST_BQ3  = 34'd1 << 26,
    ST_BQ4  = 34'd1 << 27,
    ST_CL1  = 34'd1 << 28,
    ST_AS1  = 34'd1 << 29,
    ST_ASR  = 34'd1 << 30,
    ST_AF   = 34'd1 << 31,
    ST_AG   = 34'd1 << 32,
    ST_FIN  = 34'd1 << 33
  } state_t;

  state_t state;

  // configuration
  logic [23:0]        iir_rate;
  logic [2:0]         tap_spacing;
  logic               ultrasonic_enable;
  logic signed [25:0] coef_a0;
  logic signed [25:0] coef_b1;
  logic signed [25:0] coef_b2;

  // filter state
  logic signed [31:0]         stage_a;
  logic signed [31:0]         stage_b;
  logic signed [31:0]         biquad_s1;
  logic signed [31:0]         biquad_s2;
  logic signed [SAMPLE_W-1:0] slew_taps [TAP_DEPTH];

  // working registers
  logic signed [31:0] x28;
  logic signed [32:0] kb;
  logic signed [27:0] vacc;
  logic [25:0]        ev;
  logic               bend_neg;
  logic               sin_neg;
  logic               ret_asin;
  logic [30:0]        sf;
  logic [30:0]        xr;
  logic [31:0]        x2;
  logic signed [31:0] tr;
  logic [31:0]        nr;
  logic [31:0]        qr;
  logic [2:0]         kcnt;
  logic signed [31:0] sres;
  logic signed [33:0] ff;
  logic signed [33:0] ff2;
  logic signed [31:0] obq;
  logic signed [33:0] rb1;
  logic               asin_neg;
  logic [30:0]        x30;
  logic [30:0]        fr;
  logic [4:0]         bidx;
  logic signed [SAMPLE_W-1:0] resr;

  // shared multiplier
  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [65:0] prod;

  // combinational helpers
  logic signed [26:0]         d_w;
  logic signed [26:0]         nd_w;
  logic [SAMPLE_W-1:0]        t4_mag;
  logic signed [31:0]         sval;
  logic signed [25:0]         bend_w;
  logic [32:0]                ka_w;
  logic [32:0]                rem_w;
  logic [31:0]                q1_w;
  logic signed [33:0]         yd_w;
  logic signed [27:0]         vc_w;
  logic signed [27:0]         vmag_w;
  logic signed [65:0]         rnd_a;
  logic signed [65:0]         rnd_b;
  logic signed [65:0]         rnd_ff;
  logic signed [65:0]         rnd_ff2;
  logic signed [65:0]         rnd_24;
  logic signed [65:0]         rnd_out;
  logic signed [SAMPLE_W-1:0] asin_w;
  logic                       cfg_wr;

  assign pready   = 1'b1;
  assign in_ready = (state == ST_IDLE);
  assign cfg_wr   = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (paddr[ADDR_W-1:2])
      REG_IIR_RATE:  prdata = {8'd0, iir_rate};
      REG_TAP_SPACE: prdata = {29'd0, tap_spacing};
      REG_ULTRA_EN:  prdata = {31'd0, ultrasonic_enable};
      REG_COEF_A0:   prdata = {6'd0, coef_a0};
      REG_COEF_B1:   prdata = {6'd0, coef_b1};
      REG_COEF_B2:   prdata = {6'd0, coef_b2};
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    d_w    = 27'(slew_taps[0]) - (27'(slew_taps[4]) <<< 1) + 27'(slew_taps[8]);
    nd_w   = -d_w;
    t4_mag = slew_taps[4][SAMPLE_W-1] ? SAMPLE_W'(-slew_taps[4]) : SAMPLE_W'(slew_taps[4]);
    sval   = sin_neg ? -sres : sres;
    bend_w = $signed(prod[55:30]);
    ka_w   = (stage_a[31] ? 33'(-33'(stage_a)) : 33'(stage_a)) + LEAK_Q28;
    rem_w  = {1'b0, nr} - prod[32:0];
    q1_w   = (rem_w >= 33'(div_const(kcnt))) ? qr + 32'd1 : qr;
    yd_w   = (34'(x28) - 34'(stage_b) + (34'sd1 <<< (X28_SHIFT - 1))) >>> X28_SHIFT;
    rnd_a   = (prod + (66'sd1 <<< 31)) >>> 32;
    rnd_b   = (prod + (66'sd1 <<< 27)) >>> 28;
    rnd_ff  = (prod + (66'sd1 <<< (FRAC - 5))) >>> (FRAC - 4);
    rnd_ff2 = ((prod <<< 1) + (66'sd1 <<< (FRAC - 5))) >>> (FRAC - 4);
    rnd_24  = (prod + (66'sd1 <<< 23)) >>> 24;
    rnd_out = (prod + (66'sd1 <<< (59 - FRAC))) >>> (60 - FRAC);
    asin_w  = asin_neg ? -SAMPLE_W'(rnd_out) : SAMPLE_W'(rnd_out);
    // clip to plus/minus one before the arcsine
    if (vacc > 28'(UNIT_LIM)) begin
      vc_w = 28'(UNIT_LIM);
    end else if (vacc < -28'(UNIT_LIM)) begin
      vc_w = -28'(UNIT_LIM);
    end else begin
      vc_w = vacc;
    end
    vmag_w = vc_w[27] ? -vc_w : vc_w;
  end

  // multiplier operand select: each state issues at most one product
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_HA:   begin ma = 33'(x28) - 33'(stage_a); mb = {9'd0, iir_rate}; end
      ST_HD:   begin ma = 33'(stage_a) - 33'(stage_b); mb = kb; end
      ST_BP:   begin ma = {7'd0, ev}; mb = TURN_K; end
      ST_S0:   begin ma = {2'd0, sf}; mb = PIO2_Q30; end
      ST_S1:   begin ma = {2'd0, prod[60:30]}; mb = {2'd0, prod[60:30]}; end
      ST_S3:   begin ma = {1'b0, x2}; mb = 33'(tr); end
      ST_S4:   begin ma = {1'b0, prod[61:30]}; mb = {1'b0, div_recip(kcnt)}; end
      ST_S5:   begin ma = {1'b0, prod[63:32]}; mb = {26'd0, div_const(kcnt)}; end
      ST_S7:   begin ma = {2'd0, xr}; mb = 33'(tr); end
      ST_BR0:  begin ma = 33'(t4_mag); mb = 33'(sval); end
      ST_BR1:  begin ma = $signed(prod[62:30]); mb = BEND_Q30; end
      ST_BQ0:  begin ma = 33'(vacc); mb = 33'(coef_a0); end
      ST_BQ2:  begin ma = 33'(obq); mb = 33'(coef_b1); end
      ST_BQ3:  begin ma = 33'(obq); mb = 33'(coef_b2); end
      ST_AF:   begin ma = {2'd0, fr}; mb = PIO2_Q30; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      out_valid         <= 1'b0;
      iir_rate          <= 24'd1132766;
      tap_spacing       <= SPACE_ONE;
      ultrasonic_enable <= 1'b0;
      coef_a0           <= '0;
      coef_b1           <= '0;
      coef_b2           <= '0;
      stage_a           <= '0;
      stage_b           <= '0;
      biquad_s1         <= '0;
      biquad_s2         <= '0;
      for (int i = 0; i < TAP_DEPTH; i++) begin
        slew_taps[i] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        case (paddr[ADDR_W-1:2])
          REG_IIR_RATE:  iir_rate          <= pwdata[23:0];
          REG_TAP_SPACE: tap_spacing       <= pwdata[2:0];
          REG_ULTRA_EN:  ultrasonic_enable <= pwdata[0];
          REG_COEF_A0:   coef_a0           <= $signed(pwdata[25:0]);
          REG_COEF_B1:   coef_b1           <= $signed(pwdata[25:0]);
          REG_COEF_B2:   coef_b2           <= $signed(pwdata[25:0]);
          default: ;
        endcase
      end

      // drop the result once taken; the final state reloads it itself
      if (out_valid && out_ready && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            x28   <= 32'(sample_in) <<< X28_SHIFT;
            state <= ST_HA;
          end
        end
        ST_HA: state <= ST_HB;
        ST_HB: begin
          stage_a <= sat32(40'(stage_a) + 40'(rnd_a));
          state   <= ST_HC;
        end
        ST_HC: begin
          // stage B coefficient, capped at 4.0
          kb    <= (ka_w > KB_CAP) ? $signed(KB_CAP) : $signed(ka_w);
          state <= ST_HD;
        end
        ST_HD: state <= ST_HE;
        ST_HE: begin
          stage_b <= sat32(40'(stage_b) + 40'(rnd_b));
          state   <= ST_HF;
        end
        ST_HF: begin
          // advance the delay line by the tap spacing, then push the highpass output
          case (tap_spacing)
            SPACE_NONE, SPACE_ONE: begin
              slew_taps[8] <= slew_taps[4];
              slew_taps[4] <= slew_taps[0];
            end
            SPACE_TWO: begin
              for (int i = 2; i < TAP_DEPTH; i += 2) begin
                slew_taps[i] <= slew_taps[i-2];
              end
            end
            default: begin
              for (int i = 1; i < TAP_DEPTH; i++) begin
                slew_taps[i] <= slew_taps[i-1];
              end
            end
          endcase
          slew_taps[0] <= sat_samp(40'(yd_w));
          state        <= ST_SL;
        end
        ST_SL: begin
          // bend only when the second difference passes the threshold
          if (d_w > 27'(SOFT_TH)) begin
            ev       <= 26'(d_w - 27'(SOFT_TH));
            bend_neg <= 1'b0;
            state    <= ST_BP;
          end else if (nd_w > 27'(SOFT_TH)) begin
            ev       <= 26'(nd_w - 27'(SOFT_TH));
            bend_neg <= 1'b1;
            state    <= ST_BP;
          end else begin
            vacc  <= 28'(slew_taps[0]);
            state <= ST_CLIP;
          end
        end
        ST_BP: state <= ST_BPH;
        ST_BPH: begin
          // fold the phase onto a quarter wave
          if (prod[FRAC+30]) begin
            sf <= 31'(ONE_Q30) - {1'b0, prod[FRAC +: 30]};
          end else begin
            sf <= {1'b0, prod[FRAC +: 30]};
          end
          sin_neg  <= prod[FRAC+31];
          ret_asin <= 1'b0;
          state    <= ST_S0;
        end
        ST_S0: state <= ST_S1;
        ST_S1: begin
          xr    <= prod[60:30];
          state <= ST_S2;
        end
        ST_S2: begin
          x2    <= prod[61:30];
          tr    <= $signed(ONE_Q30);
          kcnt  <= '0;
          state <= ST_S3;
        end
        ST_S3: state <= ST_S4;
        ST_S4: begin
          nr    <= prod[61:30];
          state <= ST_S5;
        end
        ST_S5: begin
          qr    <= prod[63:32];
          state <= ST_S6;
        end
        ST_S6: begin
          // reciprocal estimate is at most one short: correct it here
          tr <= $signed(ONE_Q30 - q1_w);
          if (kcnt == 3'(DIV_TERMS - 1)) begin
            state <= ST_S7;
          end else begin
            kcnt  <= kcnt + 3'd1;
            state <= ST_S3;
          end
        end
        ST_S7: state <= ST_S8;
        ST_S8: begin
          sres  <= $signed(prod[61:30]);
          state <= ret_asin ? ST_ASR : ST_BR0;
        end
        ST_BR0: state <= ST_BR1;
        ST_BR1: state <= ST_BR2;
        ST_BR2: begin
          vacc  <= bend_neg ? 28'(slew_taps[4]) - 28'(bend_w)
                            : 28'(slew_taps[4]) + 28'(bend_w);
          state <= ST_CLIP;
        end
        ST_CLIP: begin
          if (vacc > 28'(PIO2_LIM)) begin
            vacc <= 28'(PIO2_LIM);
          end else if (vacc < -28'(PIO2_LIM)) begin
            vacc <= -28'(PIO2_LIM);
          end
          state <= ultrasonic_enable ? ST_BQ0 : ST_CL1;
        end
        ST_BQ0: state <= ST_BQ1;
        ST_BQ1: begin
          ff    <= 34'(rnd_ff);
          ff2   <= 34'(rnd_ff2);
          obq   <= sat32(40'(34'(rnd_ff)) + 40'(biquad_s1));
          state <= ST_BQ2;
        end
        ST_BQ2: state <= ST_BQ3;
        ST_BQ3: begin
          rb1   <= 34'(rnd_24);
          state <= ST_BQ4;
        end
        ST_BQ4: begin
          biquad_s1 <= sat32(40'(ff2) - 40'(rb1) + 40'(biquad_s2));
          biquad_s2 <= sat32(40'(ff) - 40'(34'(rnd_24)));
          vacc      <= 28'((40'(obq) + (40'sd1 <<< (X28_SHIFT - 1))) >>> X28_SHIFT);
          state     <= ST_CL1;
        end
        ST_CL1: begin
          asin_neg <= vc_w[27];
          x30      <= 31'(vmag_w) << Q30_SHIFT;
          if (vmag_w >= 28'(UNIT_LIM)) begin
            fr    <= 31'(ONE_Q30);
            state <= ST_AF;
          end else begin
            fr    <= '0;
            bidx  <= 5'd29;
            state <= ST_AS1;
          end
        end
        ST_AS1: begin
          sf       <= fr | (31'd1 << bidx);
          ret_asin <= 1'b1;
          state    <= ST_S0;
        end
        ST_ASR: begin
          // keep the trial bit where the sine stays at or below the target
          if (sres <= $signed({1'b0, x30})) begin
            fr <= sf;
          end
          if (bidx == 5'd0) begin
            state <= ST_AF;
          end else begin
            bidx  <= bidx - 5'd1;
            state <= ST_AS1;
          end
        end
        ST_AF: state <= ST_AG;
        ST_AG: begin
          resr  <= asin_w;
          state <= ST_FIN;
        end
        ST_FIN: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            sample_out <= resr;
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
